@@ src/adhc_pkg.sv @@
// Shared types, constants and helpers of the ASCII decimal/hex converter.
package adhc_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;

   // Digit positions held by the output digit register.
   localparam int RUN_DIGITS = 10;
   localparam int HEX_DIGITS = 8;
   localparam int DIG_BITS   = 4 * RUN_DIGITS;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;

   typedef enum logic [2:0] {
      SER_IDLE,
      SER_CONVERT,
      SER_PREFIX_ZERO,
      SER_PREFIX_X,
      SER_EMIT
   } ser_state_type;

   // Hand-over of a finished token from the parser to the serialiser.
   typedef struct packed {
      logic launch;
      logic hex_mode;
      logic digit_fault;
      logic wrap_fault;
   } run_type;

   // ASCII character of one digit, 0-9 then A-F.
   function automatic logic [7:0] nibble_to_char(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib >= 4'd10) begin
         ch = CHAR_UPPER_A + {4'd0, nib - 4'd10};
      end else begin
         ch = CHAR_ZERO + {4'd0, nib};
      end
      return ch;
   endfunction

endpackage

@@ src/adhc_if.sv @@
// Valid/ready channel interfaces for the converter's character streams.
interface adhc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       token_end;

   modport source (output valid, output char_in, output token_end, input ready);
   modport sink   (input valid, input char_in, input token_end, output ready);
endinterface

interface adhc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_out;
   logic       run_last;
   logic       bad_digit;
   logic       too_wide;

   modport source (output valid, output char_out, output run_last, output bad_digit,
                   output too_wide, input ready);
   modport sink   (input valid, input char_out, input run_last, input bad_digit,
                   input too_wide, output ready);
endinterface

@@ src/adhc_parser.sv @@
// Token parser: prefix detection, digit decode and value accumulation.
module adhc_parser #(
   parameter int VALUE_BITS = adhc_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            char_in,
   input  logic                  token_end,
   input  logic                  take,
   output adhc_pkg::run_type     run,
   output logic [VALUE_BITS-1:0] value
);

   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [1:0]            pos_ff, pos_in;
   logic                  hex_ff, hex_in;
   logic                  halted_ff, halted_in;
   logic                  fault_ff, fault_in;
   logic                  wrap_ff, wrap_in;
   logic                  launch_ff, launch_in;

   logic                  accept;
   logic [3:0]            digit;
   logic                  digit_ok;
   logic [VALUE_BITS+3:0] product;
   logic [VALUE_BITS+3:0] sum;

   assign req_ready = !launch_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      digit_ok = 1'b0;
      digit    = 4'd0;
      if (char_in >= adhc_pkg::CHAR_ZERO && char_in <= adhc_pkg::CHAR_NINE) begin
         digit_ok = 1'b1;
         digit    = 4'(char_in - adhc_pkg::CHAR_ZERO);
      end else if (hex_ff && char_in >= adhc_pkg::CHAR_UPPER_A &&
                   char_in <= adhc_pkg::CHAR_UPPER_F) begin
         digit_ok = 1'b1;
         digit    = 4'(char_in - adhc_pkg::CHAR_UPPER_A) + 4'd10;
      end else if (hex_ff && char_in >= adhc_pkg::CHAR_LOWER_A &&
                   char_in <= adhc_pkg::CHAR_LOWER_F) begin
         digit_ok = 1'b1;
         digit    = 4'(char_in - adhc_pkg::CHAR_LOWER_A) + 4'd10;
      end
   end

   // x16 is a shift, x10 is x8 plus x2; top four bits show a wrap.
   always_comb begin
      if (hex_ff) begin
         product = {acc_ff, 4'd0};
      end else begin
         product = {1'b0, acc_ff, 3'd0} + {3'd0, acc_ff, 1'b0};
      end
      sum = product + (VALUE_BITS+4)'(digit);
   end

   always_comb begin
      acc_in    = acc_ff;
      pos_in    = pos_ff;
      hex_in    = hex_ff;
      halted_in = halted_ff;
      fault_in  = fault_ff;
      wrap_in   = wrap_ff;
      launch_in = launch_ff;
      if (take) begin
         // drop the token once the serialiser holds it
         acc_in    = '0;
         pos_in    = 2'd0;
         hex_in    = 1'b0;
         fault_in  = 1'b0;
         wrap_in   = 1'b0;
         launch_in = 1'b0;
      end else if (accept && !halted_ff) begin
         if (pos_ff == 2'd0 && char_in == adhc_pkg::CHAR_MINUS) begin
            halted_in = 1'b1;
         end else begin
            if (pos_ff == 2'd1 && !hex_ff && char_in == adhc_pkg::CHAR_LOWER_X &&
                acc_ff == '0 && !fault_ff) begin
               hex_in = 1'b1;
            end else begin
               acc_in = sum[VALUE_BITS-1:0];
               if (|sum[VALUE_BITS+3:VALUE_BITS]) begin
                  wrap_in = 1'b1;
               end
               if (!digit_ok) begin
                  fault_in = 1'b1;
               end
            end
            if (pos_ff != 2'd3) begin
               pos_in = pos_ff + 2'd1;
            end
            launch_in = token_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         pos_ff    <= 2'd0;
         hex_ff    <= 1'b0;
         halted_ff <= 1'b0;
         fault_ff  <= 1'b0;
         wrap_ff   <= 1'b0;
         launch_ff <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         pos_ff    <= pos_in;
         hex_ff    <= hex_in;
         halted_ff <= halted_in;
         fault_ff  <= fault_in;
         wrap_ff   <= wrap_in;
         launch_ff <= launch_in;
      end
   end

   assign run.launch      = launch_ff;
   assign run.hex_mode    = hex_ff;
   assign run.digit_fault = fault_ff;
   assign run.wrap_fault  = wrap_ff;
   assign value           = acc_ff;

endmodule

@@ src/adhc_serialiser.sv @@
// Serialiser: bit-serial binary to BCD conversion and digit-serial emission.
module adhc_serialiser #(
   parameter int VALUE_BITS = adhc_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  adhc_pkg::run_type     run,
   input  logic [VALUE_BITS-1:0] value,
   output logic                  take,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            char_out,
   output logic                  run_last,
   output logic                  bad_digit,
   output logic                  too_wide
);

   localparam int CNT_W = $clog2(VALUE_BITS);
   localparam int DW    = adhc_pkg::DIG_BITS;

   adhc_pkg::ser_state_type state_ff, state_in;

   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [CNT_W-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [DW-1:0]         dig_ff, dig_in;
   logic [3:0]            remain_ff, remain_in;
   logic                  lead_ff, lead_in;
   logic                  fault_ff, fault_in;
   logic                  wide_ff, wide_in;

   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            out_char_ff, out_char_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_bad_ff, out_bad_in;
   logic                  out_wide_ff, out_wide_in;

   logic                  out_free;
   logic [DW-1:0]         dig_adj;
   logic [63:0]           value_wide;
   logic [3:0]            top_nib;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign value_wide = 64'(value);
   assign top_nib    = dig_ff[DW-1 -: 4];
   assign take       = run.launch && (state_ff == adhc_pkg::SER_IDLE);

   // add-3 correction on every BCD digit ahead of the shift
   always_comb begin
      for (int i = 0; i < adhc_pkg::RUN_DIGITS; i++) begin
         if (dig_ff[4*i +: 4] >= 4'd5) begin
            dig_adj[4*i +: 4] = dig_ff[4*i +: 4] + 4'd3;
         end else begin
            dig_adj[4*i +: 4] = dig_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_in       = dig_ff;
      remain_in    = remain_ff;
      lead_in      = lead_ff;
      fault_in     = fault_ff;
      wide_in      = wide_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_bad_in   = out_bad_ff;
      out_wide_in  = out_wide_ff;
      out_valid_in = out_valid_ff && !rsp_ready;

      unique case (state_ff)
         adhc_pkg::SER_IDLE: begin
            if (run.launch) begin
               fault_in = run.digit_fault;
               if (run.hex_mode) begin
                  val_in     = value;
                  bit_cnt_in = '0;
                  dig_in     = '0;
                  wide_in    = run.wrap_fault;
                  state_in   = adhc_pkg::SER_CONVERT;
               end else begin
                  dig_in    = {value_wide[31:0], (DW-32)'(0)};
                  remain_in = 4'(adhc_pkg::HEX_DIGITS);
                  wide_in   = run.wrap_fault || (|value_wide[63:32]);
                  state_in  = adhc_pkg::SER_PREFIX_ZERO;
               end
            end
         end
         adhc_pkg::SER_CONVERT: begin
            // carry out of the top digit means the value passed ten digits
            dig_in = {dig_adj[DW-2:0], val_ff[VALUE_BITS-1]};
            val_in = {val_ff[VALUE_BITS-2:0], 1'b0};
            if (dig_adj[DW-1]) begin
               wide_in = 1'b1;
            end
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == CNT_W'(VALUE_BITS-1)) begin
               remain_in = 4'(adhc_pkg::RUN_DIGITS);
               lead_in   = 1'b1;
               state_in  = adhc_pkg::SER_EMIT;
            end
         end
         adhc_pkg::SER_PREFIX_ZERO: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = adhc_pkg::CHAR_ZERO;
               out_last_in  = 1'b0;
               out_bad_in   = 1'b0;
               out_wide_in  = 1'b0;
               state_in     = adhc_pkg::SER_PREFIX_X;
            end
         end
         adhc_pkg::SER_PREFIX_X: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = adhc_pkg::CHAR_LOWER_X;
               out_last_in  = 1'b0;
               out_bad_in   = 1'b0;
               out_wide_in  = 1'b0;
               lead_in      = 1'b1;
               state_in     = adhc_pkg::SER_EMIT;
            end
         end
         adhc_pkg::SER_EMIT: begin
            if (lead_ff && top_nib == 4'd0 && remain_ff != 4'd1) begin
               // skip a leading zero
               dig_in    = {dig_ff[DW-5:0], 4'd0};
               remain_in = remain_ff - 4'd1;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = adhc_pkg::nibble_to_char(top_nib);
               out_last_in  = (remain_ff == 4'd1);
               out_bad_in   = (remain_ff == 4'd1) && fault_ff;
               out_wide_in  = (remain_ff == 4'd1) && wide_ff;
               dig_in       = {dig_ff[DW-5:0], 4'd0};
               remain_in    = remain_ff - 4'd1;
               lead_in      = 1'b0;
               if (remain_ff == 4'd1) begin
                  state_in = adhc_pkg::SER_IDLE;
               end
            end
         end
         default: begin
            state_in = adhc_pkg::SER_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= adhc_pkg::SER_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      bit_cnt_ff  <= bit_cnt_in;
      dig_ff      <= dig_in;
      remain_ff   <= remain_in;
      lead_ff     <= lead_in;
      fault_ff    <= fault_in;
      wide_ff     <= wide_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_bad_ff  <= out_bad_in;
      out_wide_ff <= out_wide_in;
   end

   assign rsp_valid = out_valid_ff;
   assign char_out  = out_char_ff;
   assign run_last  = out_last_ff;
   assign bad_digit = out_bad_ff;
   assign too_wide  = out_wide_ff;

endmodule

@@ src/ascii_dec_hex_converter_core.sv @@
// Top level of the ASCII decimal/hexadecimal number converter.
//
// Feed a number token one character per word on req_port, with token_end set
// on its last character. A token that opens with "0x" is read as hexadecimal
// (either case) and comes back on rsp_port as decimal digits; any other token
// is read as decimal and comes back as "0x" and upper-case hex digits, leading
// zeros dropped and zero written as one 0. run_last marks the final character
// of a run, and only that word carries bad_digit (a character not valid in its
// base) and too_wide (the value wrapped past VALUE_BITS or needed more digits
// than a run holds). A token opening with '-' halts the block: it and every
// later token are taken and dropped until reset. Once the serialiser takes a
// token, a decimal result runs the bit-serial binary-to-BCD shifter over all
// VALUE_BITS bits and then emits the ten digit positions, leading zeros
// skipped; a hex result sends the "0x" prefix and then eight positions.
// Characters of the next token are taken while a run is emitted; once its token
// end is taken, input is held off until the serialiser takes that token. An
// output register parts the result side, so a stalled consumer only holds the
// serialiser.
module ascii_dec_hex_converter_core #(
   parameter int VALUE_BITS = adhc_pkg::VALUE_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   adhc_req_if.sink          req_port,
   adhc_rsp_if.source        rsp_port
);

   adhc_pkg::run_type     run;        // finished token, waiting for hand-over
   logic [VALUE_BITS-1:0] run_value;  // accumulated value of that token
   logic                  take;       // serialiser takes the token this cycle
   logic                  req_ready;

   // Parse and accumulate each character word as it arrives.
   adhc_parser #(
      .VALUE_BITS (VALUE_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_ready),
      .char_in   (req_port.char_in),
      .token_end (req_port.token_end),
      .take      (take),
      .run       (run),
      .value     (run_value)
   );

   assign req_port.ready = req_ready;

   // Convert the token, then emit the run one digit per cycle while the result side is not stalled.
   adhc_serialiser #(
      .VALUE_BITS (VALUE_BITS)
   ) u_serialiser (
      .clock     (clock),
      .reset     (reset),
      .run       (run),
      .value     (run_value),
      .take      (take),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .char_out  (rsp_port.char_out),
      .run_last  (rsp_port.run_last),
      .bad_digit (rsp_port.bad_digit),
      .too_wide  (rsp_port.too_wide)
   );

endmodule

@@ src/adhc_checker.sv @@
// Port-level assertions for the converter, bound to the top level.
module adhc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] char_out,
   input logic       run_last,
   input logic       bad_digit,
   input logic       too_wide
);

   // hold a stalled word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(char_out) && $stable(run_last) &&
                                  $stable(bad_digit) && $stable(too_wide))
      else $error("rsp payload changed while stalled");

   // flags only ride on the final character of a run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !run_last |-> !bad_digit && !too_wide)
      else $error("fault flag on a character other than the last");

   // only digits, upper-case hex letters and the prefix letter leave the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (char_out >= adhc_pkg::CHAR_ZERO && char_out <= adhc_pkg::CHAR_NINE) ||
                    (char_out >= adhc_pkg::CHAR_UPPER_A &&
                     char_out <= adhc_pkg::CHAR_UPPER_F) ||
                    (char_out == adhc_pkg::CHAR_LOWER_X && !run_last))
      else $error("illegal output character");

endmodule

bind ascii_dec_hex_converter_core adhc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .char_out  (rsp_port.char_out),
   .run_last  (rsp_port.run_last),
   .bad_digit (rsp_port.bad_digit),
   .too_wide  (rsp_port.too_wide)
);

@@ tb/tb.sv @@
// Self-checking testbench for the ASCII decimal/hex converter core.
`timescale 1ns / 100ps

module tb;

   localparam int  CLOCK_PERIOD = 8;
   localparam int  RESET_CYCLES = 11;
   localparam int  VALUE_BITS   = adhc_pkg::VALUE_BITS_DEFAULT;
   localparam int  RANDOM_CHARS = 150;
   localparam int  MAX_WAIT     = 13;
   // Longest run: binary-to-BCD shifting plus ten digit positions, with margin.
   localparam int  DRAIN_CYCLES = VALUE_BITS + 2 * adhc_pkg::RUN_DIGITS + 32;
   localparam int  CYCLE_LIMIT  = 200000;
   localparam logic [63:0] ACC_MASK  = (VALUE_BITS >= 64) ? ~64'd0
                                       : ((64'd1 << VALUE_BITS) - 64'd1);
   localparam logic [63:0] DEC_LIMIT = 64'd10000000000;
   localparam string HEX_GLYPHS = "0123456789ABCDEF";

   typedef logic [7:0] char_q_type[$];

   // One word of the result stream.
   typedef struct packed {
      logic [7:0] char_out;
      logic       run_last;
      logic       bad_digit;
      logic       too_wide;
   } out_word_type;

   // Mirror of the converter: token state plus the words still to come out.
   class conv_mirror;
      logic [63:0]  acc;
      logic [1:0]   pos;
      bit           hex_mode;
      bit           halted;
      bit           digit_fault;
      bit           wrap_fault;
      out_word_type awaited[$];
      int           errors;
      int           words_checked;
      int           runs;
      int           bad_runs;
      int           wide_runs;

      function new();
         clear_token();
         halted = 0;
      endfunction

      function void clear_token();
         acc         = '0;
         pos         = '0;
         hex_mode    = 0;
         digit_fault = 0;
         wrap_fault  = 0;
      endfunction

      // Fold one accepted character into the token; on token end, queue its run.
      function void note_char(input logic [7:0] c, input bit last);
         logic [63:0]  dval;
         logic [63:0]  base;
         logic [63:0]  v;
         logic [3:0]   digits [adhc_pkg::RUN_DIGITS];
         logic [7:0]   run_chars[$];
         int           n;
         bit           ok;
         bit           tw;
         out_word_type w;
         if (halted) return;
         if (pos == 2'd0 && c == adhc_pkg::CHAR_MINUS) begin
            halted = 1;
            clear_token();
            return;
         end
         if (pos == 2'd1 && !hex_mode && c == adhc_pkg::CHAR_LOWER_X &&
             acc == 0 && !digit_fault) begin
            hex_mode = 1;
         end else begin
            ok   = 1;
            dval = '0;
            if (c >= adhc_pkg::CHAR_ZERO && c <= adhc_pkg::CHAR_NINE) begin
               dval = 64'(c - adhc_pkg::CHAR_ZERO);
            end else if (hex_mode && c >= adhc_pkg::CHAR_UPPER_A &&
                         c <= adhc_pkg::CHAR_UPPER_F) begin
               dval = 64'(c - adhc_pkg::CHAR_UPPER_A) + 64'd10;
            end else if (hex_mode && c >= adhc_pkg::CHAR_LOWER_A &&
                         c <= adhc_pkg::CHAR_LOWER_F) begin
               dval = 64'(c - adhc_pkg::CHAR_LOWER_A) + 64'd10;
            end else begin
               ok = 0;
            end
            if (!ok) digit_fault = 1;
            base = hex_mode ? 64'd16 : 64'd10;
            if (acc > (ACC_MASK - dval) / base) wrap_fault = 1;
            acc = (acc * base + dval) & ACC_MASK;
         end
         if (pos != 2'd3) pos++;
         if (!last) return;

         v  = acc;
         tw = wrap_fault;
         n  = 0;
         if (hex_mode) begin
            if (v >= DEC_LIMIT) begin
               tw = 1;
               v  = v % DEC_LIMIT;
            end
            do begin
               digits[n] = 4'(v % 64'd10);
               n++;
               v = v / 64'd10;
            end while (v != 0 && n < adhc_pkg::RUN_DIGITS);
            for (int i = n - 1; i >= 0; i--) begin
               run_chars = {run_chars, adhc_pkg::CHAR_ZERO + {4'd0, digits[i]}};
            end
         end else begin
            if (v[63:32] != 0) begin
               tw        = 1;
               v[63:32]  = '0;
            end
            run_chars = {run_chars, adhc_pkg::CHAR_ZERO};
            run_chars = {run_chars, adhc_pkg::CHAR_LOWER_X};
            do begin
               digits[n] = v[3:0];
               n++;
               v = v >> 4;
            end while (v != 0 && n < adhc_pkg::HEX_DIGITS);
            for (int i = n - 1; i >= 0; i--) begin
               run_chars = {run_chars, HEX_GLYPHS[digits[i]]};
            end
         end
         foreach (run_chars[i]) begin
            w.char_out  = run_chars[i];
            w.run_last  = (i == run_chars.size() - 1);
            w.bad_digit = w.run_last ? digit_fault : 1'b0;
            w.too_wide  = w.run_last ? tw : 1'b0;
            awaited = {awaited, w};
         end
         runs++;
         if (digit_fault) bad_runs++;
         if (tw) wide_runs++;
         clear_token();
      endfunction

      // Compare one delivered word with the oldest awaited one.
      function void check_word(input out_word_type got);
         out_word_type want;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: unexpected word char_out=%h run_last=%b bad_digit=%b too_wide=%b",
                     $time, got.char_out, got.run_last, got.bad_digit, got.too_wide);
            return;
         end
         want = awaited.pop_front();
         words_checked++;
         if (got.char_out !== want.char_out) begin
            errors++;
            $display("%0t: char_out expected %h got %h", $time, want.char_out, got.char_out);
         end
         if (got.run_last !== want.run_last) begin
            errors++;
            $display("%0t: run_last expected %b got %b", $time, want.run_last, got.run_last);
         end
         if (got.bad_digit !== want.bad_digit) begin
            errors++;
            $display("%0t: bad_digit expected %b got %b", $time, want.bad_digit, got.bad_digit);
         end
         if (got.too_wide !== want.too_wide) begin
            errors++;
            $display("%0t: too_wide expected %b got %b", $time, want.too_wide, got.too_wide);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   tokens_sent = 0;
   int   chars_sent  = 0;
   bit   sink_burst  = 0;

   conv_mirror mirror = new();

   adhc_req_if req_bus ();
   adhc_rsp_if rsp_bus ();

   ascii_dec_hex_converter_core #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Guard against a hung handshake: give up well past the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[ascii_dec_hex_converter_core] ERROR");
         $finish;
      end
   end

   // Check every word that crosses the result handshake.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         mirror.check_word('{rsp_bus.char_out, rsp_bus.run_last,
                             rsp_bus.bad_digit, rsp_bus.too_wide});
      end
   end

   // Turn a text literal into a character token.
   function automatic char_q_type text_token(input string s);
      char_q_type q;
      for (int i = 0; i < s.len(); i++) q = {q, s[i]};
      return q;
   endfunction

   // Drive one token, a word per character, with token_end on the last one.
   // Hold valid across back-to-back words; drop it only for a drawn gap.
   task automatic send_token(input char_q_type chars);
      int gap;
      bit burst;
      burst = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < chars.size(); i++) begin
         gap = burst ? 0 : $urandom_range(0, MAX_WAIT);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_bus.valid     <= 1'b1;
         req_bus.char_in   <= chars[i];
         req_bus.token_end <= (i == chars.size() - 1);
         do @(posedge clock); while (!req_bus.ready);
         mirror.note_char(req_bus.char_in, req_bus.token_end);
         chars_sent++;
         @(negedge clock);
      end
      tokens_sent++;
   endtask

   // Result side: stall for a drawn number of cycles before each word, with
   // occasional stretches of constant readiness.
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 24) == 0) sink_burst = !sink_burst;
         stall = sink_burst ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         @(negedge clock);
      end
   end

   initial begin
      char_q_type tok;
      int         pick;
      int         len;
      int         sel;
      int         target;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.char_in   = '0;
      req_bus.token_end = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed tokens: zero both ways, a bare hex prefix, mixed-case hex,
      // a decimal that wraps, an upper-case X prefix, a minus inside a token,
      // the extreme byte values, and a lone x.
      send_token(text_token("0"));
      send_token(text_token("0x"));
      send_token(text_token("0xaF"));
      send_token(text_token("4294967296"));
      send_token(text_token("0X1"));
      send_token(text_token("1-"));
      send_token('{8'hFF, 8'h00});
      send_token(text_token("x"));

      // Random tokens: mostly well-formed with random content, some broken,
      // some pure noise. Keep a leading minus out until the halt phase.
      target = chars_sent + RANDOM_CHARS;
      while (chars_sent < target) begin
         tok  = {};
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            if (pick < 2) tok = text_token("4294967295");
            else if (pick < 4) tok = text_token("4294967296");
            else if (pick < 6) tok = text_token("99999999999");
            else begin
               len = $urandom_range(1, 10);
               repeat (len) tok = {tok, 8'(adhc_pkg::CHAR_ZERO + $urandom_range(0, 9))};
            end
         end else if (pick < 82) begin
            if (pick < 43) tok = text_token("0xFFFFFFFF");
            else if (pick < 46) tok = text_token("0x1ffffffff");
            else begin
               tok = text_token("0x");
               len = (pick < 50) ? $urandom_range(9, 10) : $urandom_range(0, 8);
               repeat (len) begin
                  sel = $urandom_range(0, 2);
                  if (sel == 0) begin
                     tok = {tok, 8'(adhc_pkg::CHAR_ZERO + $urandom_range(0, 9))};
                  end else if (sel == 1) begin
                     tok = {tok, 8'(adhc_pkg::CHAR_UPPER_A + $urandom_range(0, 5))};
                  end else begin
                     tok = {tok, 8'(adhc_pkg::CHAR_LOWER_A + $urandom_range(0, 5))};
                  end
               end
            end
            // Break the odd well-formed token with a stray byte.
            if ($urandom_range(0, 9) == 0) begin
               tok[$urandom_range(0, tok.size() - 1)] = 8'($urandom_range(0, 255));
            end
         end else begin
            len = $urandom_range(1, 6);
            repeat (len) tok = {tok, 8'($urandom_range(0, 255))};
         end
         if (tok[0] == adhc_pkg::CHAR_MINUS) tok[0] = adhc_pkg::CHAR_NINE;
         send_token(tok);
      end

      // Halt on a leading minus; the tokens after it must produce nothing.
      send_token(text_token("-7"));
      send_token(text_token("12"));
      send_token(text_token("0x1F"));
      req_bus.valid <= 1'b0;

      while (mirror.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d tokens (%0d characters), ending with a halt and ignored tokens",
               tokens_sent, chars_sent);
      $display("checked %0d output words over %0d runs: %0d flagged bad digit, %0d too wide",
               mirror.words_checked, mirror.runs, mirror.bad_runs, mirror.wide_runs);
      if (mirror.errors == 0 && mirror.awaited.size() == 0) begin
         $display("[ascii_dec_hex_converter_core] OK");
      end else begin
         $display("[ascii_dec_hex_converter_core] ERROR");
      end
      $finish;
   end

endmodule
